/* rtl/bblur_pkg.sv */
package bblur_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int PIX_W      = 8;
	localparam int DIM_W      = 11;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int SUM_W      = PIX_W + 4;
	localparam int CFG_IDX_W  = 2;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(256);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(256);

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [PIX_W-1:0] pixel_value;
	} in_t;

	typedef struct packed {
		logic [PIX_W-1:0] blurred_value;
		logic             frame_end;
	} out_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] pix;
		logic             first_col;
		logic             emit;
		logic             top;
		logic             bot;
		logic             left;
		logic             right;
		logic             frame_end;
	} tag_t;

endpackage

/* rtl/bblur_ctrl.sv */
module bblur_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  logic                                enable,
	input  bblur_pkg::in_t                      item,
	input  logic                                cfg_fire,
	input  logic [bblur_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bblur_pkg::DIM_W-1:0]         cfg_data,
	output logic [bblur_pkg::COL_W-1:0]         rd_addr,
	output logic                                valid_s1,
	output bblur_pkg::tag_t                     tag_s1
);

	logic [bblur_pkg::DIM_W-1:0] fw_q;
	logic [bblur_pkg::DIM_W-1:0] fh_q;
	logic [bblur_pkg::COL_W-1:0] col_q;
	logic [bblur_pkg::DIM_W-1:0] row_q;

	logic [bblur_pkg::DIM_W-1:0] eff_w;
	logic [bblur_pkg::DIM_W-1:0] eff_h;
	logic [bblur_pkg::COL_W-1:0] w_m1;
	logic                        ignore;
	logic                        last_col;
	logic                        take;
	logic                        cfg_hit;
	bblur_pkg::tag_t             tag_d;

	always_comb begin
		if (fw_q == '0) begin
			eff_w = bblur_pkg::DIM_W'(1);
		end else if (int'(fw_q) > bblur_pkg::MAX_WIDTH) begin
			eff_w = bblur_pkg::DIM_W'(bblur_pkg::MAX_WIDTH);
		end else begin
			eff_w = fw_q;
		end
		if (fh_q == '0) begin
			eff_h = bblur_pkg::DIM_W'(1);
		end else if (int'(fh_q) > bblur_pkg::MAX_HEIGHT) begin
			eff_h = bblur_pkg::DIM_W'(bblur_pkg::MAX_HEIGHT);
		end else begin
			eff_h = fh_q;
		end
		w_m1     = bblur_pkg::COL_W'(eff_w - bblur_pkg::DIM_W'(1));
		last_col = (col_q == w_m1);
		ignore   = (row_q < eff_h) && (item.mode == bblur_pkg::MODE_FLUSH);
		take     = fire && !ignore;
		cfg_hit  = cfg_fire && ((cfg_index == bblur_pkg::CFG_FRAME_WIDTH) ||
			(cfg_index == bblur_pkg::CFG_FRAME_HEIGHT));

		tag_d.col       = col_q;
		tag_d.pix       = (row_q >= eff_h) ? '0 : item.pixel_value;
		tag_d.first_col = (col_q == '0);
		tag_d.emit      = (row_q > bblur_pkg::DIM_W'(1)) ||
			((row_q == bblur_pkg::DIM_W'(1)) && !tag_d.first_col);
		tag_d.frame_end = tag_d.first_col && (row_q == eff_h + bblur_pkg::DIM_W'(1));
		if (tag_d.first_col) begin
			tag_d.top   = row_q > bblur_pkg::DIM_W'(2);
			tag_d.bot   = row_q <= eff_h;
			tag_d.left  = eff_w > bblur_pkg::DIM_W'(1);
			tag_d.right = 1'b0;
		end else begin
			tag_d.top   = row_q > bblur_pkg::DIM_W'(1);
			tag_d.bot   = row_q < eff_h;
			tag_d.left  = col_q > bblur_pkg::COL_W'(1);
			tag_d.right = 1'b1;
		end
	end

	assign rd_addr = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q     <= bblur_pkg::WIDTH_RESET;
			fh_q     <= bblur_pkg::HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_fire && (cfg_index == bblur_pkg::CFG_FRAME_WIDTH)) begin
				fw_q <= cfg_data;
			end
			if (cfg_fire && (cfg_index == bblur_pkg::CFG_FRAME_HEIGHT)) begin
				fh_q <= cfg_data;
			end
			if (cfg_hit || (take && tag_d.emit && tag_d.frame_end)) begin
				col_q <= '0;
				row_q <= '0;
			end else if (take) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + bblur_pkg::DIM_W'(1);
				end else begin
					col_q <= col_q + bblur_pkg::COL_W'(1);
				end
			end
			if (enable) begin
				valid_s1 <= take;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			tag_s1 <= tag_d;
		end
	end

endmodule

/* rtl/bblur_lines.sv */
module bblur_lines (
	input  logic                            clk,
	input  logic                            rd_en,
	input  logic [bblur_pkg::COL_W-1:0]     rd_addr,
	input  logic                            wr_en,
	input  logic [bblur_pkg::COL_W-1:0]     wr_addr,
	input  logic [bblur_pkg::PIX_W-1:0]     wr_pix,
	output logic [bblur_pkg::PIX_W-1:0]     top_rd,
	output logic [bblur_pkg::PIX_W-1:0]     mid_rd
);

	localparam int DEPTH = 2 ** bblur_pkg::COL_W;

	logic [bblur_pkg::PIX_W-1:0] upper_mem [DEPTH];
	logic [bblur_pkg::PIX_W-1:0] middle_mem [DEPTH];

	// the middle line moves up, the new pixel enters the middle line
	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr]  <= mid_rd;
			middle_mem[wr_addr] <= wr_pix;
		end
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				top_rd <= mid_rd;
				mid_rd <= wr_pix;
			end else begin
				top_rd <= upper_mem[rd_addr];
				mid_rd <= middle_mem[rd_addr];
			end
		end
	end

endmodule

/* rtl/bblur_win.sv */
module bblur_win (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            enable,
	input  logic                            valid_s1,
	input  bblur_pkg::tag_t                 tag_s1,
	input  logic [bblur_pkg::PIX_W-1:0]     top_rd,
	input  logic [bblur_pkg::PIX_W-1:0]     mid_rd,
	output logic                            out_valid_s2,
	output bblur_pkg::out_t                 out_s2
);

	logic [bblur_pkg::PIX_W-1:0] win_q   [3][3];
	logic [bblur_pkg::PIX_W-1:0] win_nxt [3][3];
	logic [bblur_pkg::SUM_W-1:0] lc      [3];
	logic [bblur_pkg::SUM_W-1:0] cc      [3];
	logic [bblur_pkg::SUM_W-1:0] rc      [3];
	logic [bblur_pkg::SUM_W-1:0] sum;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (tag_s1.first_col) begin
				win_nxt[i][0] = '0;
				win_nxt[i][1] = '0;
			end else begin
				win_nxt[i][0] = win_q[i][1];
				win_nxt[i][1] = win_q[i][2];
			end
		end
		win_nxt[0][2] = top_rd;
		win_nxt[1][2] = mid_rd;
		win_nxt[2][2] = tag_s1.pix;

		// a row start finishes the previous row's last pixel from the old window
		for (int i = 0; i < 3; i++) begin
			if (tag_s1.first_col) begin
				lc[i] = bblur_pkg::SUM_W'(win_q[i][1]);
				cc[i] = bblur_pkg::SUM_W'(win_q[i][2]);
			end else begin
				lc[i] = bblur_pkg::SUM_W'(win_nxt[i][0]);
				cc[i] = bblur_pkg::SUM_W'(win_nxt[i][1]);
			end
			rc[i] = bblur_pkg::SUM_W'(win_nxt[i][2]);
			if (!tag_s1.left) begin
				lc[i] = '0;
			end
			if (!tag_s1.right) begin
				rc[i] = '0;
			end
		end

		sum = (cc[1] << 2) + (lc[1] << 1) + (rc[1] << 1);
		if (tag_s1.top) begin
			sum = sum + (cc[0] << 1) + lc[0] + rc[0];
		end
		if (tag_s1.bot) begin
			sum = sum + (cc[2] << 1) + lc[2] + rc[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
			out_valid_s2 <= 1'b0;
		end else if (enable) begin
			if (valid_s1) begin
				win_q <= win_nxt;
			end
			out_valid_s2 <= valid_s1 && tag_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (enable && valid_s1) begin
			out_s2.blurred_value <= sum[bblur_pkg::SUM_W-1:4];
			out_s2.frame_end     <= tag_s1.frame_end;
		end
	end

endmodule

/* rtl/binomial_blur_3x3.sv */
// channel  signals                                   direction
// src      src_valid, src_ready, src (mode, pixel)   in
// dst      dst_valid, dst_ready, dst (value, end)    out
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data in
//
// one item per cycle unless dst stalls; a result goes via stage 1, then the output reg
// stage 1 reads both line stores, stage 2 updates the window and adds, then output reg
// the whole pipe stalls only while a result waits at dst; cfg is always ready
// reset clears counters and window; line stores start undefined and are never cleared
module binomial_blur_3x3 (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            src_valid,
	output logic                            src_ready,
	input  bblur_pkg::in_t                  src,
	output logic                            dst_valid,
	input  logic                            dst_ready,
	output bblur_pkg::out_t                 dst,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bblur_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bblur_pkg::DIM_W-1:0]     cfg_data
);

	logic                        enable;
	logic                        fire;
	logic                        valid_s1;
	bblur_pkg::tag_t             tag_s1;
	logic [bblur_pkg::COL_W-1:0] rd_addr;
	logic [bblur_pkg::PIX_W-1:0] top_rd;
	logic [bblur_pkg::PIX_W-1:0] mid_rd;

	assign enable    = !dst_valid || dst_ready;
	assign src_ready = enable;
	assign fire      = src_valid && enable;
	assign cfg_ready = 1'b1;

	bblur_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.enable    (enable),
		.item      (src),
		.cfg_fire  (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_addr   (rd_addr),
		.valid_s1  (valid_s1),
		.tag_s1    (tag_s1)
	);

	bblur_lines u_lines (
		.clk     (clk),
		.rd_en   (fire),
		.rd_addr (rd_addr),
		.wr_en   (valid_s1 && enable),
		.wr_addr (tag_s1.col),
		.wr_pix  (tag_s1.pix),
		.top_rd  (top_rd),
		.mid_rd  (mid_rd)
	);

	bblur_win u_win (
		.clk          (clk),
		.arst_n       (arst_n),
		.enable       (enable),
		.valid_s1     (valid_s1),
		.tag_s1       (tag_s1),
		.top_rd       (top_rd),
		.mid_rd       (mid_rd),
		.out_valid_s2 (dst_valid),
		.out_s2       (dst)
	);

endmodule
